// ===== sv/krts_pkg.sv =====
`default_nettype none
package krts_pkg;

	// Operation codes of an input transaction
	localparam logic [2:0] OP_WRITE     = 3'd0;
	localparam logic [2:0] OP_LIN_ID    = 3'd1;
	localparam logic [2:0] OP_LIN_NAME  = 3'd2;
	localparam logic [2:0] OP_BIN_ID    = 3'd3;
	localparam logic [2:0] OP_BIN_NAME  = 3'd4;

	// Field widths
	localparam int OP_W    = 3;
	localparam int IDX_W   = 6;
	localparam int ID_W    = 32;
	localparam int NAME_W  = 64;
	localparam int LIMB_W  = 8;
	localparam int SIZE_W  = 7;
	localparam int IN_W    = 120;
	localparam int OUT_W   = 112;

	// One stored record
	typedef struct packed {
		logic [LIMB_W-1:0] limbs;
		logic [NAME_W-1:0] name;
		logic [ID_W-1:0]   id;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Order of the used entries
	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_ID   = 2'd1,
		TAG_NAME = 2'd2
	} tag_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIN_RD,
		ST_LIN_CMP,
		ST_SORT_RDI,
		ST_SORT_HOLD,
		ST_SORT_RDJ,
		ST_SORT_CMP,
		ST_BIN_RD,
		ST_BIN_CMP,
		ST_EMIT
	} state_t;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_WRITE,
		CMD_LOAD,
		CMD_LIN_RD,
		CMD_LIN_CMP,
		CMD_BIN_RD,
		CMD_BIN_CMP,
		CMD_SORT_RDI,
		CMD_SORT_HOLD,
		CMD_SORT_RDJ,
		CMD_SORT_CMP,
		CMD_SORT_PUT,
		CMD_EMIT
	} cmd_t;

	// Datapath status toward the controller
	typedef struct packed {
		logic clr_last;
		logic lin_end;
		logic bin_end;
		logic sort_end;
		logic j_zero;
		logic hit;
		logic greater;
		logic out_busy;
	} sts_t;

	// Search key of a record
	function automatic logic [NAME_W-1:0] rec_key(input rec_t r, input logic by_name);
		rec_key = by_name ? r.name : {{(NAME_W-ID_W){1'b0}}, r.id};
	endfunction

endpackage
`default_nettype wire

// ===== sv/krts_ram.sv =====
`default_nettype none
module krts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/krts_ctrl.sv =====
`default_nettype none
module krts_ctrl
	import krts_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [OP_W-1:0] op,
	input  wire logic            cfg_we,
	input  wire sts_t            sts,
	output cmd_t                 cmd
);

	state_t state_q, state_d;
	tag_t   tag_q;
	logic   by_name_q;
	logic   acc;
	logic   want_name;
	tag_t   want_tag;

	assign acc       = s_tvalid && s_tready;
	assign want_name = (op == OP_BIN_NAME);
	assign want_tag  = want_name ? TAG_NAME : TAG_ID;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:     if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (acc) begin
					case (op)
						OP_LIN_ID, OP_LIN_NAME: state_d = ST_LIN_RD;
						OP_BIN_ID, OP_BIN_NAME:
							state_d = (tag_q == want_tag) ? ST_BIN_RD : ST_SORT_RDI;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LIN_RD:    state_d = sts.lin_end ? ST_EMIT : ST_LIN_CMP;
			ST_LIN_CMP:   state_d = sts.hit ? ST_EMIT : ST_LIN_RD;
			ST_SORT_RDI:  state_d = sts.sort_end ? ST_BIN_RD : ST_SORT_HOLD;
			ST_SORT_HOLD: state_d = ST_SORT_RDJ;
			ST_SORT_RDJ:  state_d = sts.j_zero ? ST_SORT_RDI : ST_SORT_CMP;
			ST_SORT_CMP:  state_d = sts.greater ? ST_SORT_RDJ : ST_SORT_RDI;
			ST_BIN_RD:    state_d = sts.bin_end ? ST_EMIT : ST_BIN_CMP;
			ST_BIN_CMP:   state_d = sts.hit ? ST_EMIT : ST_BIN_RD;
			ST_EMIT:      if (!sts.out_busy) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd      = CMD_NONE;
		case (state_q)
			ST_CLEAR: cmd = CMD_CLR;
			ST_IDLE: begin
				if (acc) begin
					case (op)
						OP_WRITE: cmd = CMD_WRITE;
						OP_LIN_ID, OP_LIN_NAME, OP_BIN_ID, OP_BIN_NAME: cmd = CMD_LOAD;
						default: cmd = CMD_NONE;
					endcase
				end
			end
			ST_LIN_RD:    if (!sts.lin_end) cmd = CMD_LIN_RD;
			ST_LIN_CMP:   cmd = CMD_LIN_CMP;
			ST_SORT_RDI:  if (!sts.sort_end) cmd = CMD_SORT_RDI;
			ST_SORT_HOLD: cmd = CMD_SORT_HOLD;
			ST_SORT_RDJ:  cmd = sts.j_zero ? CMD_SORT_PUT : CMD_SORT_RDJ;
			ST_SORT_CMP:  cmd = CMD_SORT_CMP;
			ST_BIN_RD:    if (!sts.bin_end) cmd = CMD_BIN_RD;
			ST_BIN_CMP:   cmd = CMD_BIN_CMP;
			ST_EMIT:      if (!sts.out_busy) cmd = CMD_EMIT;
			default:      cmd = CMD_NONE;
		endcase
	end

	// State, order tag and key kind of the running find
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			tag_q     <= TAG_NONE;
			by_name_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				by_name_q <= want_name;
			end
			if (cfg_we || (acc && op == OP_WRITE)) begin
				tag_q <= TAG_NONE;
			end else if (state_q == ST_SORT_RDI && sts.sort_end) begin
				tag_q <= by_name_q ? TAG_NAME : TAG_ID;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/krts_dp.sv =====
`default_nettype none
module krts_dp
	import krts_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int NAME_CHARS  = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [IN_W-1:0]   s_tdata,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} << (8 * (8 - NAME_CHARS));

	// Input fields
	logic [OP_W-1:0]   in_op;
	logic [IDX_W-1:0]  in_idx;
	logic [ID_W-1:0]   in_id;
	logic [NAME_W-1:0] in_name;
	logic [LIMB_W-1:0] in_limbs;
	rec_t              in_rec;

	assign in_op    = s_tdata[2:0];
	assign in_idx   = s_tdata[8:3];
	assign in_id    = s_tdata[40:9];
	assign in_name  = s_tdata[104:41] & NAME_MASK;
	assign in_limbs = s_tdata[112:105];
	assign in_rec   = '{limbs: in_limbs, name: in_name, id: in_id};

	logic [SIZE_W-1:0] size_q;
	logic [CW-1:0]     used;
	logic [AW-1:0]     clr_q;
	logic [NAME_W-1:0] key_q;
	logic              by_name_q;
	logic [CW-1:0]     i_q, lo_q, hi_q, si_q, j_q;
	logic [CW-1:0]     mid, jm1;
	rec_t              hold_q;
	logic              res_found_q;
	rec_t              res_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	rec_t              wdata, rdata;
	logic [NAME_W-1:0] rd_key, hold_key;

	assign used     = (int'(size_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(size_q);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign jm1      = j_q - CW'(1);
	assign rd_key   = rec_key(rdata, by_name_q);
	assign hold_key = rec_key(hold_q, by_name_q);

	krts_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Status
	always_comb begin
		sts.clr_last = (int'(clr_q) == TABLE_DEPTH - 1);
		sts.lin_end  = (i_q >= used);
		sts.bin_end  = (lo_q >= hi_q);
		sts.sort_end = (si_q >= used);
		sts.j_zero   = (j_q == '0);
		sts.hit      = (rd_key == key_q);
		sts.greater  = (rd_key > hold_key);
		sts.out_busy = out_valid_q && !m_tready;
	end

	// Memory ports
	always_comb begin
		we    = 1'b0;
		waddr = j_q[AW-1:0];
		wdata = hold_q;
		raddr = i_q[AW-1:0];
		case (cmd)
			CMD_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			CMD_WRITE: begin
				we    = (int'(in_idx) < TABLE_DEPTH);
				waddr = AW'(in_idx);
				wdata = in_rec;
			end
			CMD_SORT_CMP: begin
				we    = 1'b1;
				wdata = sts.greater ? rdata : hold_q;
			end
			CMD_SORT_PUT: we = 1'b1;
			CMD_BIN_RD:   raddr = mid[AW-1:0];
			CMD_SORT_RDI: raddr = si_q[AW-1:0];
			CMD_SORT_RDJ: raddr = jm1[AW-1:0];
			default: ;
		endcase
	end

	// Control registers: table size, clear counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd == CMD_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd == CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search registers and result
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				by_name_q   <= (in_op == OP_LIN_NAME) || (in_op == OP_BIN_NAME);
				key_q       <= ((in_op == OP_LIN_NAME) || (in_op == OP_BIN_NAME)) ?
				               in_name : {{(NAME_W-ID_W){1'b0}}, in_id};
				i_q         <= '0;
				lo_q        <= '0;
				hi_q        <= used;
				si_q        <= CW'(1);
				res_found_q <= 1'b0;
				res_q       <= '0;
			end
			CMD_LIN_CMP: begin
				i_q <= i_q + CW'(1);
				if (sts.hit) begin
					res_found_q <= 1'b1;
					res_q       <= rdata;
				end
			end
			CMD_BIN_RD: i_q <= mid;
			CMD_BIN_CMP: begin
				if (sts.hit) begin
					res_found_q <= 1'b1;
					res_q       <= rdata;
				end else if (key_q > rd_key) begin
					lo_q <= i_q + CW'(1);
				end else begin
					hi_q <= i_q;
				end
			end
			CMD_SORT_RDI:  j_q <= si_q;
			CMD_SORT_HOLD: hold_q <= rdata;
			CMD_SORT_CMP: begin
				if (sts.greater) begin
					j_q <= jm1;
				end else begin
					si_q <= si_q + CW'(1);
				end
			end
			CMD_SORT_PUT: si_q <= si_q + CW'(1);
			CMD_EMIT: out_q <= {7'd0, res_q.limbs, res_q.name, res_q.id, res_found_q};
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire

// ===== sv/keyed_record_table_search.sv =====
// Keyed record table search.
// Input stream s_*: one transaction per operation (write entry, linear find
// by id or name, binary find by id or name). Output stream m_*: one
// transaction per find, none for a write or an unknown operation.
// cfg_we/cfg_data set the number of entries in use; write only while idle.
// A linear find visits the entries in order until a hit. A binary find
// probes the middle of the remaining range until a hit or an empty range;
// when the table is not in the requested order it first runs an insertion
// sort on the record memory, which has one read and one write port.
// One operation runs at a time.
// Reset clears the record memory with s_tready low and marks the table
// unsorted. A result sits in an output register; if the receiver stalls,
// the next operation is still accepted and runs, and only waits at its own
// result until the register frees.
`default_nettype none
module keyed_record_table_search
	import krts_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int NAME_CHARS  = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// operation, entry_index, key_id, key_name, limb_count, 7 zero bits
	input  wire logic [IN_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// found, out_id, out_name, out_limbs, 7 zero bits
	output logic [OUT_W-1:0]       m_tdata,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	krts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tdata[2:0]),
		.cfg_we   (cfg_we),
		.sts      (sts),
		.cmd      (cmd)
	);

	krts_dp #(.TABLE_DEPTH(TABLE_DEPTH), .NAME_CHARS(NAME_CHARS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// ===== sv/krts_chk.sv =====
`default_nettype none
module krts_chk
	import krts_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Drop valid only after the result was taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without transaction");

	// A miss carries all-zero fields
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[104:1] == '0)
		else $error("miss with nonzero fields");

	// Padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:105] == '0)
		else $error("padding bits set");

endmodule

bind keyed_record_table_search krts_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
	import krts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 40000;
	localparam logic [2:0] OP_RSV_A = 3'd5;
	localparam logic [2:0] OP_RSV_B = 3'd6;
	localparam logic [2:0] OP_RSV_C = 3'd7;

	typedef struct {
		logic              found;
		logic [ID_W-1:0]   id;
		logic [NAME_W-1:0] name;
		logic [LIMB_W-1:0] limbs;
	} answer_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	// Shadow copy of the record table
	logic [ID_W-1:0]   tbl_id [DEPTH];
	logic [NAME_W-1:0] tbl_name [DEPTH];
	logic [LIMB_W-1:0] tbl_limbs [DEPTH];
	tag_t              tbl_order;
	int unsigned       tbl_size;

	answer_t           pending_answers[$];
	int                errors;
	int                items_sent;
	int                answers_seen;
	int                finds_hit;
	int                recv_hold;
	int                recv_stall;
	int                idle_cycles;
	bit                no_idle;

	keyed_record_table_search u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int unsigned used_count();
		return (tbl_size > DEPTH) ? DEPTH : tbl_size;
	endfunction

	function automatic logic [NAME_W-1:0] key_of(int unsigned i, bit by_name);
		return by_name ? tbl_name[i] : {{(NAME_W-ID_W){1'b0}}, tbl_id[i]};
	endfunction

	// Stable insertion sort of the used entries
	task automatic order_table(bit by_name);
		int unsigned       n;
		int unsigned       j;
		logic [ID_W-1:0]   id;
		logic [NAME_W-1:0] nm;
		logic [LIMB_W-1:0] lb;
		logic [NAME_W-1:0] k;
		n = used_count();
		for (int unsigned i = 1; i < n; i++) begin
			id = tbl_id[i];
			nm = tbl_name[i];
			lb = tbl_limbs[i];
			k = by_name ? nm : {{(NAME_W-ID_W){1'b0}}, id};
			j = i;
			while (j > 0 && key_of(j - 1, by_name) > k) begin
				tbl_id[j] = tbl_id[j-1];
				tbl_name[j] = tbl_name[j-1];
				tbl_limbs[j] = tbl_limbs[j-1];
				j--;
			end
			tbl_id[j] = id;
			tbl_name[j] = nm;
			tbl_limbs[j] = lb;
		end
		tbl_order = by_name ? TAG_NAME : TAG_ID;
	endtask

	// Apply one accepted operation to the shadow table, queue its answer
	task automatic apply_operation(logic [2:0] op, logic [IDX_W-1:0] idx,
			logic [ID_W-1:0] kid, logic [NAME_W-1:0] kname, logic [LIMB_W-1:0] lb);
		int          hit;
		bit          by_name;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		logic [NAME_W-1:0] key;
		logic [NAME_W-1:0] v;
		answer_t     a;
		hit = -1;
		by_name = (op == OP_LIN_NAME || op == OP_BIN_NAME);
		key = by_name ? kname : {{(NAME_W-ID_W){1'b0}}, kid};
		case (op)
			OP_WRITE: begin
				tbl_id[idx] = kid;
				tbl_name[idx] = kname;
				tbl_limbs[idx] = lb;
				tbl_order = TAG_NONE;
				return;
			end
			OP_LIN_ID, OP_LIN_NAME: begin
				for (int unsigned i = 0; i < used_count(); i++)
					if (hit < 0 && key_of(i, by_name) == key)
						hit = i;
			end
			OP_BIN_ID, OP_BIN_NAME: begin
				if (tbl_order != (by_name ? TAG_NAME : TAG_ID))
					order_table(by_name);
				lo = 0;
				hi = used_count();
				while (lo < hi && hit < 0) begin
					mid = lo + (hi - lo) / 2;
					v = key_of(mid, by_name);
					if (v == key)
						hit = mid;
					else if (key > v)
						lo = mid + 1;
					else
						hi = mid;
				end
			end
			default: return;
		endcase
		if (hit >= 0) begin
			a = '{1'b1, tbl_id[hit], tbl_name[hit], tbl_limbs[hit]};
		end else begin
			a = '{1'b0, '0, '0, '0};
		end
		pending_answers.push_back(a);
	endtask

	// Offer one operation and hold it until the transaction completes
	task automatic send_item(logic [2:0] op, logic [IDX_W-1:0] idx,
			logic [ID_W-1:0] kid, logic [NAME_W-1:0] kname, logic [LIMB_W-1:0] lb);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, lb, kname, kid, idx, op};
		do
			@(posedge clk);
		while (!s_tready);
		apply_operation(op, idx, kid, kname, lb);
		items_sent++;
	endtask

	// Drain, let the last write settle, then set the table size
	task automatic set_table_size(logic [SIZE_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl_size = 32'(value);
		tbl_order = TAG_NONE;
	endtask

	task automatic report_mismatch(string what, logic [NAME_W-1:0] got,
			logic [NAME_W-1:0] want);
		$display("mismatch %s: got %h, expected %h (result %0d)", what, got, want,
			answers_seen);
		errors++;
	endtask

	// Receiver: check each result, stall at random or for a long hold
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[63:0], '0);
			end else begin
				a = pending_answers.pop_front();
				if (m_tdata[0] !== a.found)
					report_mismatch("found", 64'(m_tdata[0]), 64'(a.found));
				if (m_tdata[32:1] !== a.id)
					report_mismatch("out_id", 64'(m_tdata[32:1]), 64'(a.id));
				if (m_tdata[96:33] !== a.name)
					report_mismatch("out_name", m_tdata[96:33], a.name);
				if (m_tdata[104:97] !== a.limbs)
					report_mismatch("out_limbs", 64'(m_tdata[104:97]), 64'(a.limbs));
				if (a.found)
					finds_hit++;
			end
			answers_seen++;
			recv_stall = no_idle ? 0 : $urandom_range(0, 4);
		end
		if (recv_hold > 0) begin
			recv_hold--;
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_answers.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [NAME_W-1:0] pick_name();
		case ($urandom_range(0, 3))
			0: return {$urandom(), $urandom()};
			1: return {8'h41 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3)), 48'd0};
			default: return {8'h41 + 8'($urandom_range(0, 2)), 56'd0};
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		return ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 12));
	endfunction

	// Empty table, then a full all-zero table, extremes and unknown codes
	task automatic test_directed();
		send_item(OP_LIN_ID, 0, 0, 0, 0);
		send_item(OP_BIN_NAME, 0, 0, 0, 0);
		set_table_size(7'd64);
		send_item(OP_LIN_ID, 0, 0, 0, 0);
		send_item(OP_LIN_NAME, 0, 32'd5, 0, 0);
		send_item(OP_WRITE, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_item(OP_WRITE, 6'd0, 32'h8000_0000, 64'h4142_4344_4546_4748, 8'h80);
		send_item(OP_WRITE, 6'd5, 32'h8000_0000, 64'h4100_0000_0000_0000, 8'h01);
		send_item(OP_LIN_ID, 0, 32'h8000_0000, 0, 0);
		send_item(OP_LIN_NAME, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_item(OP_BIN_ID, 0, 32'hFFFF_FFFF, 0, 0);
		send_item(OP_BIN_ID, 0, 32'h8000_0000, 0, 0);
		send_item(OP_BIN_NAME, 0, 0, 64'h4142_4344_4546_4748, 0);
		send_item(OP_BIN_NAME, 0, 0, 64'h4100_0000_0000_0001, 0);
		send_item(OP_RSV_A, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_item(OP_RSV_B, 0, 0, 0, 0);
		send_item(OP_RSV_C, 0, 0, 0, 0);
		send_item(OP_BIN_ID, 0, 0, 0, 0);
		// Size change drops the sort order; oversized table acts as full
		set_table_size(7'd127);
		send_item(OP_BIN_ID, 0, 32'hFFFF_FFFF, 0, 0);
		send_item(OP_LIN_ID, 0, 32'hFFFF_FFFF, 0, 0);
		set_table_size(7'd1);
		send_item(OP_LIN_NAME, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_item(OP_BIN_NAME, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
	endtask

	// Random writes and finds at one table size; most keys are present
	task automatic test_random(logic [SIZE_W-1:0] size, int count, int write_pct);
		int unsigned n;
		int unsigned pick;
		logic [2:0]  op;
		set_table_size(size);
		n = (int'(size) > DEPTH) ? DEPTH : int'(size);
		for (int i = 0; i < count; i++) begin
			no_idle = (i % 40) >= 30;
			pick = (n == 0) ? 0 : $urandom_range(0, n - 1);
			if ($urandom_range(0, 99) < write_pct) begin
				send_item(OP_WRITE, ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'(pick),
					pick_id(), pick_name(), 8'($urandom()));
			end else if ($urandom_range(0, 19) == 0) begin
				op = 3'($urandom_range(5, 7));
				send_item(op, 6'($urandom()), $urandom(), pick_name(), 8'($urandom()));
			end else begin
				op = 3'($urandom_range(1, 4));
				if (n > 0 && $urandom_range(0, 9) < 7)
					send_item(op, 6'($urandom()), tbl_id[pick], tbl_name[pick], 8'($urandom()));
				else
					send_item(op, 6'($urandom()), pick_id(), pick_name(), 8'($urandom()));
			end
		end
		no_idle = 1'b0;
	endtask

	// Long receiver hold while the sender keeps offering finds
	task automatic test_backpressure();
		set_table_size(7'd8);
		recv_hold = 300;
		for (int i = 0; i < 30; i++)
			send_item(3'($urandom_range(1, 2)), 0, tbl_id[i % 8], tbl_name[(i + 3) % 8], 0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		answers_seen = 0;
		finds_hit = 0;
		recv_hold = 0;
		recv_stall = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_id[i] = '0;
			tbl_name[i] = '0;
			tbl_limbs[i] = '0;
		end
		tbl_order = TAG_NONE;
		tbl_size = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);

		test_directed();
		test_random(7'd1, 50, 30);
		test_random(7'd3, 90, 35);
		test_random(7'd8, 100, 35);
		test_random(7'd16, 100, 30);
		test_random(7'd5, 80, 40);
		test_backpressure();
		test_random(7'd64, 40, 15);
		test_random(7'd100, 40, 15);
		test_random(7'd127, 40, 15);
		test_random(7'd0, 20, 30);

		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d operations over table sizes 0..127, %0d results (%0d hits),",
			items_sent, answers_seen, finds_hit);
		$display("random stalls on both sides and one long receiver hold; %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
